@@ rtl/spcc_pkg.sv @@
package spcc_pkg;

	// Default coordinate width (signed Q16.16)
	localparam int COORD_BITS_DEF = 32;

	// Width of a sum of three squared coordinate differences
	function automatic int d2_bits(input int cw);
		return 2 * (cw + 1) + 2;
	endfunction

	// Width of the per-item side data: radius a, radius b, dx, dy, dz, collide flag
	function automatic int side_bits(input int cw);
		return 2 * (cw - 1) + 3 * (cw + 1) + 1;
	endfunction

endpackage

@@ rtl/sphere_pair_collision_check_top.sv @@
// Channel  Dir  Payload
// s_axis   in   s_tdata: a_x,a_y,a_z,b_x,b_y,b_z,vel_x,vel_y,vel_z,radius_a,radius_b
// m_axis   out  m_tdata: impact_a_x/y/z, impact_b_x/y/z; m_tuser: colliding
//
// One sphere pair is accepted per cycle while s_tready is high, and one result is returned per pair.
// A result passes three front stages, the middle queue, 2*COORD_BITS + 4 back
// stages for the bit-per-stage square root and dividers, and the output queue.
// arst_n clears all valid state at once; no clearing pass is needed.
// A stalled m_tready fills a two-entry output queue, then a two-entry queue
// between the classifier front and the scaling back, then holds s_tready low.
module sphere_pair_collision_check_top #(
	parameter int COORD_BITS = spcc_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, vel_x, vel_y, vel_z, radius_a, radius_b, zero fill
	input  logic [((11*COORD_BITS-2+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// impact_a_x, impact_a_y, impact_a_z, impact_b_x, impact_b_y, impact_b_z, zero fill
	output logic [((6*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// colliding
	output logic [0:0] m_tuser
);

	localparam int CW  = COORD_BITS;
	localparam int IW  = 11 * CW - 2;
	localparam int QDW = spcc_pkg::d2_bits(CW) + spcc_pkg::side_bits(CW);
	localparam int OW  = 6 * CW + 1;
	localparam int MDW = ((6*CW+7)/8)*8;

	logic           fq_valid, fq_ready;
	logic [QDW-1:0] fq_data;
	logic           qb_valid, qb_ready;
	logic [QDW-1:0] qb_data;
	logic           bo_valid, bo_ready;
	logic [OW-1:0]  bo_data;
	logic [OW-1:0]  res;

	spcc_front #(.CW(CW), .IW(IW), .QDW(QDW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata[IW-1:0]),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_data  (fq_data)
	);

	spcc_fifo #(.W(QDW)) u_mid_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	spcc_back #(.CW(CW), .QDW(QDW), .OW(OW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qb_valid),
		.in_ready  (qb_ready),
		.in_data   (qb_data),
		.out_valid (bo_valid),
		.out_ready (bo_ready),
		.out_data  (bo_data)
	);

	spcc_fifo #(.W(OW)) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bo_valid),
		.in_ready  (bo_ready),
		.in_data   (bo_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// Drive the result ports
	assign m_tuser = res[0 +: 1];
	assign m_tdata = MDW'(res[OW-1:1]);

`ifndef SYNTH
	a_zero_when_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("impact without collision");
	a_opposite_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tdata[0 +: CW] != '0 && m_tdata[3*CW +: CW] != '0
		|-> m_tdata[CW-1] != m_tdata[4*CW-1])
		else $error("impacts on A and B point the same way");
	a_tdata_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> (6*CW)) == '0)
		else $error("fill bits of m_tdata set");
`endif

endmodule

@@ rtl/spcc_fifo.sv @@
module spcc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] mem_q [0:1];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	// Full and empty come straight from the count register
	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("fifo count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("fifo lost an entry");
	a_rd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_q != $past(rd_q)) else $error("fifo read pointer stuck");
`endif

endmodule

@@ rtl/spcc_front.sv @@
module spcc_front #(
	parameter int CW  = spcc_pkg::COORD_BITS_DEF,
	parameter int IW  = 11 * CW - 2,
	parameter int QDW = spcc_pkg::d2_bits(CW) + spcc_pkg::side_bits(CW)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [IW-1:0]  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [QDW-1:0] out_data
);

	localparam int RW  = CW - 1;
	localparam int DW  = CW + 1;
	localparam int EW  = CW + 2;
	localparam int D2W = spcc_pkg::d2_bits(CW);
	localparam int E2W = 2 * EW + 2;

	logic          en;
	logic          v1_s1, v2_s2, v3_s3;
	logic [CW-1:0] ax, ay, az, bx, by, bz, vx, vy, vz;
	logic [RW-1:0] ra, rb;
	logic [DW-1:0] dx_c, dy_c, dz_c;
	logic [EW-1:0] ex_c, ey_c, ez_c;

	logic [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [EW-1:0] ex_s1, ey_s1, ez_s1;
	logic [RW-1:0] ra_s1, rb_s1;
	logic [CW-1:0] rs_s1;

	logic [DW-1:0] mdx, mdy, mdz;
	logic [EW-1:0] mex, mey, mez;

	logic [2*DW-1:0] dxx_s2, dyy_s2, dzz_s2;
	logic [2*EW-1:0] exx_s2, eyy_s2, ezz_s2;
	logic [2*CW-1:0] rs2_s2;
	logic [DW-1:0]   dx_s2, dy_s2, dz_s2;
	logic [RW-1:0]   ra_s2, rb_s2;

	logic [D2W-1:0]  d2_s3;
	logic [E2W-1:0]  e2_s3;
	logic [2*CW-1:0] rs2_s3;
	logic [DW-1:0]   dx_s3, dy_s3, dz_s3;
	logic [RW-1:0]   ra_s3, rb_s3;
	logic            overlap, approach;

	// Unpack the input item
	assign ax = in_data[0*CW +: CW];
	assign ay = in_data[1*CW +: CW];
	assign az = in_data[2*CW +: CW];
	assign bx = in_data[3*CW +: CW];
	assign by = in_data[4*CW +: CW];
	assign bz = in_data[5*CW +: CW];
	assign vx = in_data[6*CW +: CW];
	assign vy = in_data[7*CW +: CW];
	assign vz = in_data[8*CW +: CW];
	assign ra = in_data[9*CW +: RW];
	assign rb = in_data[9*CW+RW +: RW];

	// Stall only when the last stage holds an item the queue cannot take
	assign en       = !v3_s3 || out_ready;
	assign in_ready = en;

	// Offsets d = B - A and e = d - vel
	assign dx_c = {bx[CW-1], bx} - {ax[CW-1], ax};
	assign dy_c = {by[CW-1], by} - {ay[CW-1], ay};
	assign dz_c = {bz[CW-1], bz} - {az[CW-1], az};
	assign ex_c = {dx_c[DW-1], dx_c} - {{2{vx[CW-1]}}, vx};
	assign ey_c = {dy_c[DW-1], dy_c} - {{2{vy[CW-1]}}, vy};
	assign ez_c = {dz_c[DW-1], dz_c} - {{2{vz[CW-1]}}, vz};

	// Magnitudes for squaring
	assign mdx = dx_s1[DW-1] ? -dx_s1 : dx_s1;
	assign mdy = dy_s1[DW-1] ? -dy_s1 : dy_s1;
	assign mdz = dz_s1[DW-1] ? -dz_s1 : dz_s1;
	assign mex = ex_s1[EW-1] ? -ex_s1 : ex_s1;
	assign mey = ey_s1[EW-1] ? -ey_s1 : ey_s1;
	assign mez = ez_s1[EW-1] ? -ez_s1 : ez_s1;

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else if (en) begin
			v1_s1 <= in_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	// Payload: differences, squares, sums of squares
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			dz_s1  <= dz_c;
			ex_s1  <= ex_c;
			ey_s1  <= ey_c;
			ez_s1  <= ez_c;
			ra_s1  <= ra;
			rb_s1  <= rb;
			rs_s1  <= {1'b0, ra} + {1'b0, rb};

			dxx_s2 <= (2*DW)'(mdx) * (2*DW)'(mdx);
			dyy_s2 <= (2*DW)'(mdy) * (2*DW)'(mdy);
			dzz_s2 <= (2*DW)'(mdz) * (2*DW)'(mdz);
			exx_s2 <= (2*EW)'(mex) * (2*EW)'(mex);
			eyy_s2 <= (2*EW)'(mey) * (2*EW)'(mey);
			ezz_s2 <= (2*EW)'(mez) * (2*EW)'(mez);
			rs2_s2 <= (2*CW)'(rs_s1) * (2*CW)'(rs_s1);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			ra_s2  <= ra_s1;
			rb_s2  <= rb_s1;

			d2_s3  <= D2W'(dxx_s2) + D2W'(dyy_s2) + D2W'(dzz_s2);
			e2_s3  <= E2W'(exx_s2) + E2W'(eyy_s2) + E2W'(ezz_s2);
			rs2_s3 <= rs2_s2;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			dz_s3  <= dz_s2;
			ra_s3  <= ra_s2;
			rb_s3  <= rb_s2;
		end
	end

	// Classify: overlapping and approaching
	assign overlap   = d2_s3 < D2W'(rs2_s3);
	assign approach  = e2_s3 < E2W'(d2_s3);
	assign out_valid = v3_s3;
	assign out_data  = {d2_s3, overlap && approach, dz_s3, dy_s3, dx_s3, rb_s3, ra_s3};

endmodule

@@ rtl/spcc_back.sv @@
module spcc_back #(
	parameter int CW  = spcc_pkg::COORD_BITS_DEF,
	parameter int QDW = spcc_pkg::d2_bits(CW) + spcc_pkg::side_bits(CW),
	parameter int OW  = 6 * CW + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [QDW-1:0] in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [OW-1:0]  out_data
);

	localparam int RW  = CW - 1;
	localparam int DW  = CW + 1;
	localparam int D2W = spcc_pkg::d2_bits(CW);
	localparam int SW  = spcc_pkg::side_bits(CW);
	localparam int RTW = D2W / 2;
	localparam int NW  = DW + RW;
	localparam int LW  = RTW + RW;
	localparam int NST = RTW + RW + 3;
	localparam int LN  = 6;

	logic           adv;
	logic [NST-1:0] vld_q;

	logic [D2W-1:0] sq_rem_s  [0:RTW];
	logic [RTW-1:0] sq_root_s [0:RTW];
	logic [SW-1:0]  sq_side_s [0:RTW];
	logic [D2W-1:0] sq_rem_n  [0:RTW-1];
	logic [RTW-1:0] sq_root_n [0:RTW-1];

	logic [RTW-1:0] rl_len_q;
	logic [SW-1:0]  rl_side_q;

	logic [NW-1:0]  dv_num_s  [0:LN-1][0:RW];
	logic [RW-1:0]  dv_quo_s  [0:LN-1][0:RW];
	logic [NW-1:0]  dv_num_n  [0:LN-1][0:RW-1];
	logic [RW-1:0]  dv_quo_n  [0:LN-1][0:RW-1];
	logic [RTW-1:0] dv_len_s  [0:RW];
	logic [SW-1:0]  dv_side_s [0:RW];

	logic [NW-1:0]  prod      [0:LN-1];
	logic [CW-1:0]  impact    [0:LN-1];
	logic [SW-1:0]  fin_side;

	// Whole pipeline moves together; a bubble at the end never blocks it
	assign adv      = out_ready || !vld_q[NST-1];
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NST-2:0], in_valid};
	end

	// Square root, one result bit per stage
	always_comb begin
		logic [D2W:0] trial;
		logic [D2W:0] diff;
		for (int k = 0; k < RTW; k++) begin
			trial = ((D2W+1)'(sq_root_s[k]) << (RTW - k))
				| ((D2W+1)'(1) << (2 * (RTW - 1 - k)));
			diff  = {1'b0, sq_rem_s[k]} - trial;
			if (!diff[D2W]) begin
				sq_rem_n[k]  = diff[D2W-1:0];
				sq_root_n[k] = sq_root_s[k] | (RTW'(1) << (RTW - 1 - k));
			end else begin
				sq_rem_n[k]  = sq_rem_s[k];
				sq_root_n[k] = sq_root_s[k];
			end
		end
	end

	// Products |d_i| * radius for the six lanes
	always_comb begin
		logic [DW-1:0] dsel;
		logic [DW-1:0] dmag;
		logic [RW-1:0] rsel;
		for (int l = 0; l < LN; l++) begin
			dsel    = rl_side_q[2*RW + (l % 3)*DW +: DW];
			dmag    = dsel[DW-1] ? -dsel : dsel;
			rsel    = (l < 3) ? rl_side_q[0 +: RW] : rl_side_q[RW +: RW];
			prod[l] = NW'(dmag) * NW'(rsel);
		end
	end

	// Long division by the length, one quotient bit per stage
	always_comb begin
		logic [LW:0] diff;
		for (int l = 0; l < LN; l++) begin
			for (int j = 0; j < RW; j++) begin
				diff = {1'b0, LW'(dv_num_s[l][j])}
					- {1'b0, (LW'(dv_len_s[j]) << (RW - 1 - j))};
				if (!diff[LW]) begin
					dv_num_n[l][j] = diff[NW-1:0];
					dv_quo_n[l][j] = dv_quo_s[l][j] | (RW'(1) << (RW - 1 - j));
				end else begin
					dv_num_n[l][j] = dv_num_s[l][j];
					dv_quo_n[l][j] = dv_quo_s[l][j];
				end
			end
		end
	end

	// Advance the payload of all stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem_s[0]  <= in_data[SW +: D2W];
			sq_root_s[0] <= '0;
			sq_side_s[0] <= in_data[SW-1:0];
			for (int k = 0; k < RTW; k++) begin
				sq_rem_s[k+1]  <= sq_rem_n[k];
				sq_root_s[k+1] <= sq_root_n[k];
				sq_side_s[k+1] <= sq_side_s[k];
			end

			// Round to nearest, ties down
			rl_len_q  <= sq_root_s[RTW]
				+ RTW'(sq_rem_s[RTW] > D2W'(sq_root_s[RTW]));
			rl_side_q <= sq_side_s[RTW];

			dv_len_s[0]  <= rl_len_q;
			dv_side_s[0] <= rl_side_q;
			for (int l = 0; l < LN; l++) begin
				dv_num_s[l][0] <= prod[l];
				dv_quo_s[l][0] <= '0;
				for (int j = 0; j < RW; j++) begin
					dv_num_s[l][j+1] <= dv_num_n[l][j];
					dv_quo_s[l][j+1] <= dv_quo_n[l][j];
				end
			end
			for (int j = 0; j < RW; j++) begin
				dv_len_s[j+1]  <= dv_len_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	// Apply sign; zero the result when there is no collision
	assign fin_side = dv_side_s[RW];
	always_comb begin
		logic neg;
		for (int l = 0; l < LN; l++) begin
			neg = fin_side[2*RW + (l % 3)*DW + DW - 1] ^ (l >= 3);
			if (!fin_side[SW-1]) impact[l] = '0;
			else if (neg) impact[l] = -CW'(dv_quo_s[l][RW]);
			else impact[l] = CW'(dv_quo_s[l][RW]);
		end
	end

	assign out_valid = vld_q[NST-1];
	assign out_data  = {impact[5], impact[4], impact[3], impact[2], impact[1], impact[0],
		fin_side[SW-1]};

endmodule
